[rtl/firmata_byte_lexer_top_assert.svh]
// assertion macros for the firmata byte lexer checker
// no dependencies; included by the checker file only
`ifndef FIRMATA_BYTE_LEXER_TOP_ASSERT_SVH
`define FIRMATA_BYTE_LEXER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FBL_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fbl check failed");

// next-cycle implication, disabled during reset
`define FBL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fbl check failed");

`endif

[rtl/fbl_pkg.sv]
// firmata byte lexer package: modes, token kinds, command bytes and the lexer function
// no dependencies; used by the top level and the checker
`default_nettype none

package fbl_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_SYSEX  = 2'd1,
    MODE_CAPS   = 2'd2,
    MODE_RAW    = 2'd3
  } mode_e;

  localparam logic [4:0] KIND_VERSION     = 5'd0;
  localparam logic [4:0] KIND_PIN_MODE    = 5'd1;
  localparam logic [4:0] KIND_DIG_PIN     = 5'd2;
  localparam logic [4:0] KIND_START       = 5'd3;
  localparam logic [4:0] KIND_STOP        = 5'd4;
  localparam logic [4:0] KIND_ANALOG      = 5'd5;
  localparam logic [4:0] KIND_DIGITAL     = 5'd6;
  localparam logic [4:0] KIND_DATA        = 5'd7;
  localparam logic [4:0] KIND_FIRMWARE    = 5'd8;
  localparam logic [4:0] KIND_STRING      = 5'd9;
  localparam logic [4:0] KIND_SAMPLING    = 5'd10;
  localparam logic [4:0] KIND_CAP_QUERY   = 5'd11;
  localparam logic [4:0] KIND_CAP_RESP    = 5'd12;
  localparam logic [4:0] KIND_AMAP_QUERY  = 5'd13;
  localparam logic [4:0] KIND_AMAP_RESP   = 5'd14;
  localparam logic [4:0] KIND_PSTATE_QUERY = 5'd15;
  localparam logic [4:0] KIND_PSTATE_RESP = 5'd16;
  localparam logic [4:0] KIND_CAP_END     = 5'd17;

  localparam logic [7:0] BYTE_VERSION      = 8'hF9;
  localparam logic [7:0] BYTE_PIN_MODE     = 8'hF4;
  localparam logic [7:0] BYTE_DIG_PIN      = 8'hF5;
  localparam logic [7:0] BYTE_START        = 8'hF0;
  localparam logic [7:0] BYTE_STOP         = 8'hF7;
  localparam logic [3:0] NIB_ANALOG        = 4'hE;
  localparam logic [3:0] NIB_DIGITAL       = 4'h9;
  localparam logic [7:0] BYTE_FIRMWARE     = 8'h79;
  localparam logic [7:0] BYTE_STRING       = 8'h71;
  localparam logic [7:0] BYTE_SAMPLING     = 8'h7A;
  localparam logic [7:0] BYTE_CAP_QUERY    = 8'h6B;
  localparam logic [7:0] BYTE_CAP_RESP     = 8'h6C;
  localparam logic [7:0] BYTE_AMAP_QUERY   = 8'h69;
  localparam logic [7:0] BYTE_AMAP_RESP    = 8'h6A;
  localparam logic [7:0] BYTE_PSTATE_QUERY = 8'h6D;
  localparam logic [7:0] BYTE_PSTATE_RESP  = 8'h6E;
  localparam logic [7:0] BYTE_CAP_END      = 8'h7F;

  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] value;
    logic       has_channel;
    logic [3:0] channel;
    mode_e      new_mode;
  } token_t;

  function automatic token_t lex_byte(input logic [7:0] b, input mode_e mode);
    token_t t;
    t.kind        = KIND_DATA;
    t.value       = '0;
    t.has_channel = 1'b0;
    t.channel     = '0;
    t.new_mode    = mode;
    unique case (mode)
      MODE_NORMAL: begin
        unique case (b)
          BYTE_VERSION:  t.kind = KIND_VERSION;
          BYTE_PIN_MODE: t.kind = KIND_PIN_MODE;
          BYTE_DIG_PIN:  t.kind = KIND_DIG_PIN;
          BYTE_START: begin
            t.kind     = KIND_START;
            t.new_mode = MODE_SYSEX;
          end
          BYTE_STOP:     t.kind = KIND_STOP;
          default: begin
            if (b[7:4] == NIB_ANALOG) begin
              t.kind        = KIND_ANALOG;
              t.has_channel = 1'b1;
              t.channel     = b[3:0];
            end else if (b[7:4] == NIB_DIGITAL) begin
              t.kind        = KIND_DIGITAL;
              t.has_channel = 1'b1;
              t.channel     = b[3:0];
            end
          end
        endcase
      end
      MODE_SYSEX: begin
        t.new_mode = MODE_RAW;
        unique case (b)
          BYTE_FIRMWARE:     t.kind = KIND_FIRMWARE;
          BYTE_STRING:       t.kind = KIND_STRING;
          BYTE_SAMPLING:     t.kind = KIND_SAMPLING;
          BYTE_CAP_QUERY:    t.kind = KIND_CAP_QUERY;
          BYTE_CAP_RESP: begin
            t.kind     = KIND_CAP_RESP;
            t.new_mode = MODE_CAPS;
          end
          BYTE_AMAP_QUERY:   t.kind = KIND_AMAP_QUERY;
          BYTE_AMAP_RESP:    t.kind = KIND_AMAP_RESP;
          BYTE_PSTATE_QUERY: t.kind = KIND_PSTATE_QUERY;
          BYTE_PSTATE_RESP:  t.kind = KIND_PSTATE_RESP;
          BYTE_STOP: begin
            t.kind     = KIND_STOP;
            t.new_mode = MODE_NORMAL;
          end
          default:           t.kind = KIND_DATA;
        endcase
      end
      MODE_CAPS: begin
        if (b == BYTE_CAP_END) begin
          t.kind = KIND_CAP_END;
        end else if (b == BYTE_STOP) begin
          t.kind     = KIND_STOP;
          t.new_mode = MODE_NORMAL;
        end
      end
      MODE_RAW: begin
        if (b == BYTE_STOP) begin
          t.kind     = KIND_STOP;
          t.new_mode = MODE_NORMAL;
        end
      end
      default: t.new_mode = MODE_NORMAL;
    endcase
    if (t.kind == KIND_DATA) begin
      t.value = b;
    end
    return t;
  endfunction

endpackage

`default_nettype wire

[rtl/firmata_byte_lexer_top.sv]
// firmata byte lexer top level: input register, lexer logic, result register
// depends on fbl_pkg
//
// channel | direction | handshake               | payload
// in      | in        | in_valid_i / in_ready_o  | rx_byte_i
// out     | out       | out_valid_o / out_ready_i| token_kind_o, token_value_o,
//         |           |                          | has_channel_o, channel_o, new_mode_o
//
// one byte per cycle while results are taken; each byte passes both registers
// the lexer mode register is updated as a byte moves into the result register
// reset returns the mode to normal and empties both stages
// with the result stalled, the input register still takes one more byte
`default_nettype none

module firmata_byte_lexer_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [4:0]      token_kind_o,
  output logic [7:0]      token_value_o,
  output logic            has_channel_o,
  output logic [3:0]      channel_o,
  output logic [1:0]      new_mode_o
);

  logic            in_valid_q;
  logic [7:0]      in_byte_q;
  logic            out_valid_q;
  fbl_pkg::token_t out_tok_q;
  fbl_pkg::token_t tok_d;
  fbl_pkg::mode_e  mode_q;
  logic            advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign tok_d      = fbl_pkg::lex_byte(in_byte_q, mode_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= fbl_pkg::MODE_NORMAL;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        mode_q      <= tok_d.new_mode;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance) begin
      out_tok_q <= tok_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign token_kind_o  = out_tok_q.kind;
  assign token_value_o = out_tok_q.value;
  assign has_channel_o = out_tok_q.has_channel;
  assign channel_o     = out_tok_q.channel;
  assign new_mode_o    = out_tok_q.new_mode;

endmodule

`default_nettype wire

[rtl/fbl_checker.sv]
// port-level checker for the firmata byte lexer, bound to the top level
// depends on fbl_pkg and firmata_byte_lexer_top_assert.svh
`default_nettype none

`include "firmata_byte_lexer_top_assert.svh"

module fbl_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic [7:0] rx_byte_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [4:0] token_kind_o,
  input wire logic [7:0] token_value_o,
  input wire logic       has_channel_o,
  input wire logic [3:0] channel_o,
  input wire logic [1:0] new_mode_o
);

  // a stalled input transfer holds its byte
  `FBL_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o,
    in_valid_i && $stable(rx_byte_i))

  // a stalled result holds
  `FBL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(token_kind_o) && $stable(token_value_o))

  // channel only on analog or digital io
  `FBL_ASSERT_SAME(a_channel_kind, clk_i, rst_ni, out_valid_o && has_channel_o,
    token_kind_o == fbl_pkg::KIND_ANALOG || token_kind_o == fbl_pkg::KIND_DIGITAL)

  // value is zero unless a data transfer
  `FBL_ASSERT_SAME(a_value_data, clk_i, rst_ni,
    out_valid_o && token_kind_o != fbl_pkg::KIND_DATA, token_value_o == 8'd0)

  // end of sysex always returns to normal
  `FBL_ASSERT_SAME(a_stop_normal, clk_i, rst_ni,
    out_valid_o && token_kind_o == fbl_pkg::KIND_STOP,
    new_mode_o == fbl_pkg::MODE_NORMAL && !has_channel_o && channel_o == 4'd0)

endmodule

bind firmata_byte_lexer_top fbl_checker u_fbl_checker (.*);

`default_nettype wire
